// ===== sv/sensor_reply_frame_parser_assert.svh =====
// Assertion macros for the sensor reply frame parser.
`ifndef SENSOR_REPLY_FRAME_PARSER_ASSERT_SVH
`define SENSOR_REPLY_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/srfp_pkg.sv =====
package srfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned READ_W   = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned POS_W    = 5;

    localparam logic [BYTE_W-1:0] HEAD_BYTE = 8'hCC;
    localparam logic [BYTE_W-1:0] CMD_BYTE  = 8'h70;
    localparam logic [BYTE_W-1:0] LEN_BYTE  = 8'h0C;

    localparam logic [POS_W-1:0] POS_HEAD    = 5'd0;
    localparam logic [POS_W-1:0] POS_ADDR    = 5'd1;
    localparam logic [POS_W-1:0] POS_CMD     = 5'd2;
    localparam logic [POS_W-1:0] POS_LEN     = 5'd3;
    localparam logic [POS_W-1:0] POS_X_LAST  = 5'd7;
    localparam logic [POS_W-1:0] POS_Y_LAST  = 5'd11;
    localparam logic [POS_W-1:0] POS_T_LAST  = 5'd15;
    localparam logic [POS_W-1:0] POS_SUM     = 5'd16;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HEAD  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ADDR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CMD   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LEN   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SUM   = 3'd6;

    localparam int unsigned OUT_BITS = STATUS_W + 3 * READ_W;
    localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [READ_W-1:0] x_reading;
        logic signed [READ_W-1:0] y_reading;
        logic signed [READ_W-1:0] t_reading;
    } t_result;

endpackage

// ===== sv/sensor_reply_frame_parser.sv =====
// Channel   Direction  tdata (low bit up)                       tuser        tlast
// s_axis    in         rx_byte[7:0]                             frame_first  frame_last
// m_axis    out        status[2:0] x[34:3] y[66:35] t[98:67]    -            -
// cfg       in         expected_address[7:0] on i_cfg_wr_data, written when i_cfg_wr_en
//
// One byte per cycle, unless a finished result is held back by m_axis_tready; a result
// is registered in the input register and then in the result register.
// Reset is synchronous, active low; the parser idles until a byte with tuser set.
// A stalled result holds the input stage only when that stage carries another result.
`include "sensor_reply_frame_parser_assert.svh"

module sensor_reply_frame_parser
    import srfp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,  // expected_address
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // rx_byte[7:0]
    input  logic             s_axis_tuser,   // frame_first
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // status[2:0], x[34:3], y[66:35], t[98:67], zeros
);

    logic [BYTE_W-1:0]   r_addr;

    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_in_first;
    logic                r_in_last;

    logic [POS_W-1:0]    r_pos, n_pos;
    logic [BYTE_W-1:0]   r_sum, n_sum;
    logic [STATUS_W-1:0] r_err, n_err;
    logic [READ_W-1:0]   r_xs, n_xs;
    logic [READ_W-1:0]   r_ys, n_ys;
    logic [READ_W-1:0]   r_ts, n_ts;
    logic                r_done, n_done;

    logic                r_out_valid;
    t_result             r_out, n_out;

    logic                res_valid;
    logic                adv;

    logic [POS_W-1:0]    c_pos;
    logic [BYTE_W-1:0]   c_sum;
    logic [STATUS_W-1:0] c_err;
    logic [READ_W-1:0]   c_xs, c_ys, c_ts;
    logic                c_done;

    always_comb begin
        c_pos  = r_in_first ? '0 : r_pos;
        c_sum  = r_in_first ? '0 : r_sum;
        c_err  = r_in_first ? ST_OK : r_err;
        c_xs   = r_in_first ? '0 : r_xs;
        c_ys   = r_in_first ? '0 : r_ys;
        c_ts   = r_in_first ? '0 : r_ts;
        c_done = r_in_first ? 1'b0 : r_done;

        n_pos  = c_pos;
        n_sum  = c_sum;
        n_err  = c_err;
        n_xs   = c_xs;
        n_ys   = c_ys;
        n_ts   = c_ts;
        n_done = c_done;
        res_valid = 1'b0;
        n_out  = '{status: ST_OK, x_reading: '0, y_reading: '0, t_reading: '0};

        if (!c_done) begin
            if (c_pos >= POS_ADDR && c_pos <= POS_T_LAST) begin
                n_sum = c_sum + r_in_byte;
            end
            priority if (c_pos == POS_HEAD) begin
                if (r_in_byte != HEAD_BYTE && c_err == ST_OK) n_err = ST_HEAD;
            end else if (c_pos == POS_ADDR) begin
                if (r_in_byte != r_addr && c_err == ST_OK) n_err = ST_ADDR;
            end else if (c_pos == POS_CMD) begin
                if (r_in_byte != CMD_BYTE && c_err == ST_OK) n_err = ST_CMD;
            end else if (c_pos == POS_LEN) begin
                if (r_in_byte != LEN_BYTE && c_err == ST_OK) n_err = ST_LEN;
            end else if (c_pos <= POS_X_LAST) begin
                n_xs = {c_xs[READ_W-BYTE_W-1:0], r_in_byte};
            end else if (c_pos <= POS_Y_LAST) begin
                n_ys = {c_ys[READ_W-BYTE_W-1:0], r_in_byte};
            end else if (c_pos <= POS_T_LAST) begin
                n_ts = {c_ts[READ_W-BYTE_W-1:0], r_in_byte};
            end else begin
                if (r_in_byte != c_sum && c_err == ST_OK) n_err = ST_SUM;
            end

            if (c_pos == POS_SUM) begin
                res_valid    = 1'b1;
                n_done       = 1'b1;
                n_out.status = n_err;
                if (n_err == ST_OK) begin
                    n_out.x_reading = c_xs;
                    n_out.y_reading = c_ys;
                    n_out.t_reading = c_ts;
                end
            end else begin
                n_pos = c_pos + 1'b1;
                if (r_in_last) begin
                    res_valid    = 1'b1;
                    n_done       = 1'b1;
                    n_out.status = ST_SHORT;
                end
            end
        end
    end

    assign adv           = r_in_valid && (!res_valid || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}},
                            r_out.t_reading, r_out.y_reading, r_out.x_reading, r_out.status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cfg_wr_en) begin
            r_addr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_first <= s_axis_tuser;
            r_in_last  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_err  <= ST_OK;
            r_xs   <= '0;
            r_ys   <= '0;
            r_ts   <= '0;
            r_done <= 1'b1;
        end else if (adv) begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_err  <= n_err;
            r_xs   <= n_xs;
            r_ys   <= n_ys;
            r_ts   <= n_ts;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res_valid) begin
            r_out <= n_out;
        end
    end

    `SRFP_ASSERT_NOW(a_err_zero_readings, i_clk, i_rst_n,
        r_out_valid && r_out.status != ST_OK,
        r_out.x_reading == '0 && r_out.y_reading == '0 && r_out.t_reading == '0,
        "failed frame carries nonzero readings")
    `SRFP_ASSERT_NOW(a_status_range, i_clk, i_rst_n,
        r_out_valid, r_out.status <= ST_SUM, "result status out of range")
    `SRFP_ASSERT_NOW(a_pos_range, i_clk, i_rst_n,
        1'b1, r_pos <= POS_SUM, "byte position past checksum")
    `SRFP_ASSERT_NEXT(a_done_after_result, i_clk, i_rst_n,
        adv && res_valid, r_done && r_out_valid, "parser not idle after a result")

endmodule
